// ===== rtl/tmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Markup code stripper package
// Character codes, skip lengths and result types shared by the stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcs_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_C_LO  = 8'h63;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;

  localparam logic [2:0] SKIP_C      = 3'd6;
  localparam logic [2:0] SKIP_A      = 3'd2;
  localparam logic [2:0] SKIP_F_MODE0 = 3'd2;
  localparam logic [2:0] SKIP_F_MODE1 = 3'd1;

  localparam logic MODE_KEEP  = 1'b0;
  localparam logic MODE_ESC   = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_string;
    logic       last_of_run;
  } result_t;

  function automatic logic is_plain_code(input logic [7:0] b);
    logic hit;
    begin
      case (b) inside
        8'h62, 8'h69, 8'h72, 8'h6F, 8'h43, 8'h41, 8'h46, 8'h42, 8'h49: hit = 1'b1;
        default: hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/text_markup_code_stripper.sv =====
// ----------------------------------------------------------------------------
// Text markup code stripper
// Removes caret markup codes from a zero-terminated byte stream.
// ----------------------------------------------------------------------------
// One byte enters per cycle through a one-item input register while the result
// queue holds at most two results; the decode is combinational, the escape
// and skip state is registered, and the zero, one or two results of the byte
// go into a four-entry result queue that drives the output one result per
// cycle while the receiver is ready. The sustained rate is one item per cycle
// while items produce at most one result each; an item that produces two
// results (a kept caret followed by another byte, or a kept caret before the
// terminator) uses the output port once per result, so the rate is bounded
// by the output port. A byte passes the input register and then the result
// queue; strip_mode is written on the cfg channel, which is always ready.
`default_nettype none

module text_markup_code_stripper
  import tmcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // end_of_string
  output logic      [0:0] m_tuser,   // [0] last_of_run
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data   // strip_mode
);

  logic              strip_mode;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic              escape_pending;
  logic [2:0]        skip_remaining;
  logic              escape_pending_next;
  logic [2:0]        skip_remaining_next;

  result_t           queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic              advance;
  logic              pop;
  logic [1:0]        n_res;
  logic [7:0]        res0_byte;
  logic [7:0]        res1_byte;
  logic              res0_eos;
  logic              res1_eos;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign s_tready  = !in_valid || advance;
  assign pop       = m_tvalid && m_tready;

  always_comb begin
    escape_pending_next = escape_pending;
    skip_remaining_next = skip_remaining;
    n_res     = 2'd0;
    res0_byte = in_byte;
    res1_byte = in_byte;
    res0_eos  = 1'b0;
    res1_eos  = 1'b0;
    if (in_byte == CH_NUL) begin
      escape_pending_next = 1'b0;
      skip_remaining_next = 3'd0;
      if (escape_pending && skip_remaining == 3'd0 && strip_mode == MODE_KEEP) begin
        n_res     = 2'd2;
        res0_byte = CH_CARET;
        res1_byte = CH_NUL;
        res1_eos  = 1'b1;
      end else begin
        n_res     = 2'd1;
        res0_byte = CH_NUL;
        res0_eos  = 1'b1;
      end
    end else if (skip_remaining != 3'd0) begin
      skip_remaining_next = skip_remaining - 3'd1;
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (in_byte == CH_C_LO) begin
        skip_remaining_next = SKIP_C;
      end else if (in_byte == CH_A_LO) begin
        skip_remaining_next = SKIP_A;
      end else if (in_byte == CH_F_LO) begin
        skip_remaining_next = (strip_mode == MODE_ESC) ? SKIP_F_MODE1 : SKIP_F_MODE0;
      end else if (is_plain_code(in_byte)) begin
        n_res = 2'd0;
      end else if (in_byte == CH_CARET) begin
        if (strip_mode == MODE_KEEP) begin
          n_res     = 2'd1;
          res0_byte = CH_CARET;
        end else begin
          escape_pending_next = 1'b1;
        end
      end else if (strip_mode == MODE_KEEP) begin
        n_res     = 2'd2;
        res0_byte = CH_CARET;
        res1_byte = in_byte;
      end else begin
        n_res = 2'd1;
      end
    end else if (in_byte == CH_CARET) begin
      escape_pending_next = 1'b1;
    end else begin
      n_res = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_mode     <= MODE_KEEP;
      in_valid       <= 1'b0;
      escape_pending <= 1'b0;
      skip_remaining <= 3'd0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        strip_mode <= cfg_data;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        escape_pending <= escape_pending_next;
        skip_remaining <= skip_remaining_next;
        wr_ptr         <= wr_ptr + QPTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (advance ? QCNT_W'(n_res) : QCNT_W'(0)) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
    if (advance && n_res != 2'd0) begin
      queue[wr_ptr] <= '{out_byte: res0_byte, end_of_string: res0_eos,
                         last_of_run: (n_res == 2'd1)};
    end
    if (advance && n_res == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= '{out_byte: res1_byte, end_of_string: res1_eos,
                                     last_of_run: 1'b1};
    end
  end

  assign m_tvalid   = (count != '0);
  assign m_tdata    = queue[rd_ptr].out_byte;
  assign m_tlast    = queue[rd_ptr].end_of_string;
  assign m_tuser[0] = queue[rd_ptr].last_of_run;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_skip_excludes_escape: assert property (@(posedge clk) disable iff (rst)
    skip_remaining != 3'd0 |-> !escape_pending)
    else $error("skip run and pending escape at once");

  a_terminator_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_byte == CH_NUL |=> !escape_pending && skip_remaining == 3'd0)
    else $error("state not cleared after terminator");

  a_eos_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("terminator result not marked last of run");

endmodule

`default_nettype wire
